### rtl/trie_max_xor_search_assert.svh
// Assertion macros for the trie max-XOR search block.
// Used by modules that check their own logic; no other dependencies.
`ifndef TRIE_MAX_XOR_SEARCH_ASSERT_SVH
`define TRIE_MAX_XOR_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define TMX_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset
`define TMX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMX_ASSERT_IMPL(lbl, ante, cons, msg)
`define TMX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/tmx_pkg.sv
// Shared types and constants for the trie max-XOR search block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package tmx_pkg;

    // Width of the key field on the stream
    localparam int KEY_W         = 32;
    // Default configuration
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_MAX_NODES = 4096;

    // Command codes carried in tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_WALK   = 5'b00100,
        S_ALLOC  = 5'b01000,
        S_FINISH = 5'b10000
    } tmx_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;      // write zeros at the clear counter
        logic start;      // load a new word, read the root
        logic walk;       // advance one trie level
        logic alloc;      // link a new node at the current level
        logic set_full;   // flag the insert as dropped
        logic mark_keys;  // an insert succeeded
        logic load_out;   // move the result into the output register
    } tmx_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_query;   // incoming word is a query
        logic is_query;   // word in progress is a query
        logic holds_keys; // trie holds at least one key
        logic child_hit;  // child on the key's own bit exists
        logic no_room;    // too few free nodes for the rest of the key
        logic level_zero; // current level is bit 0
        logic clear_done; // clear counter at the last node
        logic out_busy;   // output register holds a word not yet taken
    } tmx_stat_t;

endpackage

`default_nettype wire

### rtl/trie_max_xor_search.sv
// Binary trie maximum-XOR search. Slave stream: tuser[0] command (0 insert,
// 1 query), tdata key. Master stream: tdata greatest XOR, tuser[0] found,
// tuser[1] store full (insert dropped, trie unchanged).
// One result word per input word, in order. One word is in work at a time;
// a finished word waits in the output register while the next one is taken.
// Each word walks one trie level per cycle through the two child-pointer
// RAMs (registered read). An insert whose path ends at a missing child
// first checks that the rest of the key fits, then links one new node per
// level; a dropped insert ends after that check. A query on an empty trie
// skips the walk. The result word turns valid in the cycle s_axis_tready
// rises again.
// After reset the child RAMs are cleared one node per cycle, all MAX_NODES
// nodes, during which s_axis_tready stays low.
// A stalled receiver holds the finished word in the output register; the
// block then finishes the word in work and waits for the register to free.
// Depends on tmx_pkg, tmx_ctrl and tmx_dpath.
`timescale 1ns / 1ps
`default_nettype none

module trie_max_xor_search #(
    parameter int KEY_BITS  = tmx_pkg::DEF_KEY_BITS,
    parameter int MAX_NODES = tmx_pkg::DEF_MAX_NODES
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [tmx_pkg::KEY_W-1:0] s_axis_tdata,  // [31:0] key_value
    input  wire logic [0:0]                s_axis_tuser,  // [0] command
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [tmx_pkg::KEY_W-1:0]      m_axis_tdata,  // [31:0] xor_result
    output logic [1:0]                     m_axis_tuser   // [0] found, [1] store_full
);

    import tmx_pkg::*;

    tmx_cmd_t  cmd;
    tmx_stat_t stat;
    logic      found;
    logic      full;

    tmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmx_dpath #(
        .KEY_BITS  (KEY_BITS),
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_command (s_axis_tuser[0]),
        .in_key     (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_xor    (m_axis_tdata),
        .out_found  (found),
        .out_full   (full)
    );

    // Result flags
    assign m_axis_tuser = {full, found};

endmodule

`default_nettype wire

### rtl/tmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tmx_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/tmx_ctrl.sv
// Controller state machine for the trie max-XOR search block.
// Depends on tmx_pkg; drives the datapath through tmx_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tmx_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tmx_pkg::tmx_stat_t  stat,
    output tmx_pkg::tmx_cmd_t        cmd
);

    import tmx_pkg::*;

    tmx_state_t state_reg;
    tmx_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_ready && in_valid;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    // empty trie: a query has nothing to walk
                    if (stat.in_query && !stat.holds_keys)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.is_query)
                begin
                    if (stat.level_zero)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (stat.child_hit)
                begin
                    // duplicate key ends on an existing leaf
                    if (stat.level_zero)
                    begin
                        cmd.mark_keys = 1'b1;
                        state_next    = S_FINISH;
                    end
                end
                else if (stat.no_room)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc = 1'b1;
                if (stat.level_zero)
                begin
                    cmd.mark_keys = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tmx_dpath.sv
// Datapath for the trie max-XOR search: node stores, walk registers, output word.
// Depends on tmx_pkg, tmx_ram and trie_max_xor_search_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "trie_max_xor_search_assert.svh"

module tmx_dpath #(
    parameter int KEY_BITS  = tmx_pkg::DEF_KEY_BITS,
    parameter int MAX_NODES = tmx_pkg::DEF_MAX_NODES
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_command,
    input  wire logic [tmx_pkg::KEY_W-1:0] in_key,
    input  wire tmx_pkg::tmx_cmd_t         cmd,
    output tmx_pkg::tmx_stat_t             stat,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [tmx_pkg::KEY_W-1:0]      out_xor,
    output logic                           out_found,
    output logic                           out_full
);

    import tmx_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = NODE_W + 1;
    localparam int SUM_W  = NODE_W + 2;
    localparam int LVL_W  = $clog2(KEY_BITS);

    // Walk state
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] best_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [LVL_W-1:0]    level_reg;
    logic                is_query_reg;
    logic                full_reg;
    // Trie bookkeeping
    logic [CNT_W-1:0]    next_free_reg;
    logic                holds_keys_reg;
    logic [NODE_W-1:0]   clr_cnt_reg;
    // Output word
    logic                out_valid_reg;
    logic [KEY_W-1:0]    xor_reg;
    logic                found_reg;
    logic                full_out_reg;

    logic [KEY_BITS-1:0] key_in;
    logic [KEY_W-1:0]    best_out;
    logic [NODE_W-1:0]   zero_rd;
    logic [NODE_W-1:0]   one_rd;
    logic                key_bit;
    logic [NODE_W-1:0]   c_same;
    logic [NODE_W-1:0]   c_opp;
    logic                take_opp;
    logic [NODE_W-1:0]   next_node;
    logic [NODE_W-1:0]   rd_addr;
    logic [NODE_W-1:0]   wr_addr;
    logic [NODE_W-1:0]   wr_data;
    logic                zero_we;
    logic                one_we;
    logic [SUM_W-1:0]    need_sum;
    logic                advance;
    logic                out_busy;

    // Key and result width adaptation
    generate
        if (KEY_BITS <= KEY_W)
        begin : g_key_narrow
            assign key_in = in_key[KEY_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key_in = {{(KEY_BITS-KEY_W){1'b0}}, in_key};
        end
        if (KEY_BITS >= KEY_W)
        begin : g_res_wide
            assign best_out = best_reg[KEY_W-1:0];
        end
        else
        begin : g_res_narrow
            assign best_out = {{(KEY_W-KEY_BITS){1'b0}}, best_reg};
        end
    endgenerate

    // Child decode for the current level
    assign key_bit   = key_reg[level_reg];
    assign c_same    = key_bit ? one_rd : zero_rd;
    assign c_opp     = key_bit ? zero_rd : one_rd;
    assign take_opp  = is_query_reg && (c_opp != '0);
    assign next_node = take_opp ? c_opp : c_same;
    assign advance   = cmd.walk && (is_query_reg || (c_same != '0));

    // Node store ports
    assign rd_addr = cmd.start ? '0 : next_node;
    assign wr_addr = cmd.clear ? clr_cnt_reg : node_reg;
    assign wr_data = cmd.clear ? '0 : next_free_reg[NODE_W-1:0];
    assign zero_we = cmd.clear || (cmd.alloc && !key_bit);
    assign one_we  = cmd.clear || (cmd.alloc && key_bit);

    tmx_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_zero_child (
        .clk   (clk),
        .we    (zero_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (zero_rd)
    );

    tmx_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_one_child (
        .clk   (clk),
        .we    (one_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (one_rd)
    );

    // Nodes still needed: one per level from here down to bit 0
    assign need_sum = SUM_W'(next_free_reg) + SUM_W'(level_reg) + SUM_W'(1);
    assign out_busy = out_valid_reg && !out_ready;

    // Status to the controller
    always_comb
    begin
        stat.in_query   = (in_command == CMD_QUERY);
        stat.is_query   = is_query_reg;
        stat.holds_keys = holds_keys_reg;
        stat.child_hit  = (c_same != '0);
        stat.no_room    = (need_sum > SUM_W'(MAX_NODES));
        stat.level_zero = (level_reg == '0);
        stat.clear_done = (clr_cnt_reg == NODE_W'(MAX_NODES - 1));
        stat.out_busy   = out_busy;
    end

    // Walk registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg      <= key_in;
            best_reg     <= '0;
            node_reg     <= '0;
            level_reg    <= LVL_W'(KEY_BITS - 1);
            is_query_reg <= (in_command == CMD_QUERY);
            full_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                node_reg  <= next_node;
                level_reg <= level_reg - LVL_W'(1);
                if (take_opp)
                begin
                    best_reg[level_reg] <= 1'b1;
                end
            end
            if (cmd.alloc)
            begin
                node_reg  <= next_free_reg[NODE_W-1:0];
                level_reg <= level_reg - LVL_W'(1);
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // Trie bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= CNT_W'(1);
            holds_keys_reg <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            end
            if (cmd.alloc)
            begin
                next_free_reg <= next_free_reg + CNT_W'(1);
            end
            if (cmd.mark_keys)
            begin
                holds_keys_reg <= 1'b1;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            xor_reg      <= best_out;
            found_reg    <= is_query_reg && holds_keys_reg;
            full_out_reg <= full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_xor   = xor_reg;
    assign out_found = found_reg;
    assign out_full  = full_out_reg;

    // Checks
    `TMX_ASSERT_NEXT(a_keys_stay, holds_keys_reg, holds_keys_reg, "trie emptied after an insert")
    `TMX_ASSERT_IMPL(a_alloc_room, cmd.alloc, next_free_reg < CNT_W'(MAX_NODES), "node overrun")
    `TMX_ASSERT_IMPL(a_flags_excl, out_valid_reg, !(found_reg && full_out_reg), "found and full")
    `TMX_ASSERT_IMPL(a_xor_found, out_valid_reg && (xor_reg != '0), found_reg, "xor without hit")

endmodule

`default_nettype wire

### verif/trie_xor_checker.sv
// Checker for the trie max-XOR search block: watches both stream channels,
// keeps its own copy of the trie and compares every result word in order.
// Depends on tmx_pkg for the command codes and the default sizes.
`timescale 1ns / 1ps

module trie_xor_checker #(
    parameter int KEY_BITS  = tmx_pkg::DEF_KEY_BITS,
    parameter int MAX_NODES = tmx_pkg::DEF_MAX_NODES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] key_value
    input  logic [0:0]  s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] xor_result
    input  logic [1:0]  m_axis_tuser,   // [0] found, [1] store_full
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [31:0] xor_result;
        logic        found;
        logic        store_full;
    } result_word_t;

    // Shadow trie: child pointers, 0 means no child
    logic [11:0]  zero_link [0:MAX_NODES-1];
    logic [11:0]  one_link  [0:MAX_NODES-1];
    int           free_node;
    bit           has_keys;

    result_word_t xor_outcomes [$];
    result_word_t want;
    result_word_t got;

    // Walk the existing path, then allocate the rest only if all of it fits
    function automatic bit insert_key(input logic [31:0] key);
        int          node;
        int          lvl;
        logic [11:0] nxt;
        node = 0;
        lvl  = KEY_BITS - 1;
        while (lvl >= 0)
        begin
            nxt = key[lvl] ? one_link[node] : zero_link[node];
            if (nxt == 0)
                break;
            node = nxt;
            lvl--;
        end
        if (free_node + lvl + 1 > MAX_NODES)
            return 1'b0;
        while (lvl >= 0)
        begin
            if (key[lvl])
                one_link[node] = free_node[11:0];
            else
                zero_link[node] = free_node[11:0];
            node = free_node;
            free_node++;
            lvl--;
        end
        has_keys = 1'b1;
        return 1'b1;
    endfunction

    // Greedy walk: prefer the branch opposite to the key bit
    function automatic logic [31:0] max_xor_of(input logic [31:0] key);
        int          node;
        logic [11:0] other;
        logic [31:0] best;
        node = 0;
        best = '0;
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--)
        begin
            other = key[lvl] ? zero_link[node] : one_link[node];
            if (other != 0)
            begin
                best[lvl] = 1'b1;
                node = other;
            end
            else
            begin
                node = key[lvl] ? one_link[node] : zero_link[node];
            end
        end
        return best;
    endfunction

    function automatic result_word_t predict_word(input logic cmd, input logic [31:0] key);
        result_word_t w;
        w.xor_result = '0;
        w.found      = 1'b0;
        w.store_full = 1'b0;
        if (cmd == tmx_pkg::CMD_INSERT)
            w.store_full = !insert_key(key);
        else if (has_keys)
        begin
            w.xor_result = max_xor_of(key);
            w.found      = 1'b1;
        end
        return w;
    endfunction

    // Compare outgoing words first, then record the incoming one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < MAX_NODES; n++)
            begin
                zero_link[n] = '0;
                one_link[n]  = '0;
            end
            free_node = 1;
            has_keys  = 1'b0;
            xor_outcomes.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.xor_result = m_axis_tdata;
                got.found      = m_axis_tuser[0];
                got.store_full = m_axis_tuser[1];
                if (xor_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual xor %h found %b full %b",
                             $time, got.xor_result, got.found, got.store_full);
                    fail_count++;
                end
                else
                begin
                    want = xor_outcomes.pop_front();
                    if (got.xor_result !== want.xor_result)
                    begin
                        $display("%0t: xor_result mismatch, expected %h actual %h",
                                 $time, want.xor_result, got.xor_result);
                        fail_count++;
                    end
                    if (got.found !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %b actual %b",
                                 $time, want.found, got.found);
                        fail_count++;
                    end
                    if (got.store_full !== want.store_full)
                    begin
                        $display("%0t: store_full mismatch, expected %b actual %b",
                                 $time, want.store_full, got.store_full);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                xor_outcomes.insert(xor_outcomes.size(),
                                    predict_word(s_axis_tuser[0], s_axis_tdata));
            pending = xor_outcomes.size();
        end
    end

endmodule

### verif/tb.sv
// Top of the trie max-XOR search testbench: clock, reset, stimulus and verdict.
// Depends on tmx_pkg, trie_max_xor_search and trie_xor_checker.
`timescale 1ns / 1ps

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] key_value
    logic [0:0]  s_axis_tuser = '0;     // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] xor_result
    logic [1:0]  m_axis_tuser;          // [0] found, [1] store_full

    int          fail_count;
    int          pending;

    // Stimulus state
    logic [31:0] sent_keys [$];
    bit          tx_quiet;
    bit          rx_quiet;
    int          rx_hold;

    trie_max_xor_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    trie_xor_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_stored();
        if (sent_keys.size() == 0)
            return $urandom;
        return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    endfunction

    // Same prefix as base above bit k, bit k flipped, random below
    function automatic logic [31:0] near_key(input logic [31:0] base);
        int          k;
        logic [31:0] below;
        k = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31);
        below = (32'h1 << k) - 32'h1;
        return base ^ (32'h1 << k) ^ ($urandom & below);
    endfunction

    // Present one word and hold it until accepted
    task automatic send_word(input logic cmd, input logic [31:0] key);
        int gap;
        gap = pick_gap(tx_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= cmd;
        if (cmd == tmx_pkg::CMD_INSERT)
            sent_keys.insert(sent_keys.size(), key);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop sending until every outstanding result word has arrived
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                send_word(tmx_pkg::CMD_INSERT, $urandom);
            else if (r < 8)
                send_word(tmx_pkg::CMD_INSERT, near_key(pick_stored()));
            else if (r < 9)
                send_word(tmx_pkg::CMD_INSERT, pick_stored());
            else
                send_word(tmx_pkg::CMD_INSERT, $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
        end
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_word(tmx_pkg::CMD_QUERY, $urandom);
            else if (r < 6)
                send_word(tmx_pkg::CMD_QUERY, pick_stored());
            else if (r < 8)
                send_word(tmx_pkg::CMD_QUERY, ~pick_stored());
            else if (r < 9)
                send_word(tmx_pkg::CMD_QUERY, near_key(pick_stored()));
            else
                send_word(tmx_pkg::CMD_QUERY, $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
        end
    endtask

    // Receiver: random stall stretches
    initial
    begin
        rx_hold = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_hold = pick_gap(rx_quiet);
            end
        end
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty trie queries
        send_word(tmx_pkg::CMD_QUERY,  32'h0000_0000);
        send_word(tmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        // Single key, then a duplicate of it
        send_word(tmx_pkg::CMD_INSERT, 32'h0000_0000);
        send_word(tmx_pkg::CMD_QUERY,  32'h0000_0000);
        send_word(tmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        send_word(tmx_pkg::CMD_INSERT, 32'h0000_0000);
        send_word(tmx_pkg::CMD_QUERY,  32'h8000_0000);
        // Opposite extreme and a few patterns
        send_word(tmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_word(tmx_pkg::CMD_QUERY,  32'h0000_0000);
        send_word(tmx_pkg::CMD_QUERY,  32'h8000_0000);
        send_word(tmx_pkg::CMD_INSERT, 32'h8000_0000);
        send_word(tmx_pkg::CMD_INSERT, 32'h0000_0001);
        send_word(tmx_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        send_word(tmx_pkg::CMD_INSERT, 32'h5555_5555);
        send_word(tmx_pkg::CMD_QUERY,  32'h1234_5678);
        send_word(tmx_pkg::CMD_QUERY,  32'hAAAA_AAAA);
        send_word(tmx_pkg::CMD_QUERY,  32'h7FFF_FFFF);
        send_word(tmx_pkg::CMD_INSERT, 32'hFFFF_FFFE);
        send_word(tmx_pkg::CMD_QUERY,  32'h0000_0001);
        drain_results();

        // Random phases; fresh keys fill the store early, close keys then
        // use up the last free nodes and most later inserts get dropped
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_quiet = (ph == 1);
            rx_quiet = (ph == 2);
            for (int n = 0; n < 250; n++)
                send_random_word();
            drain_results();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Latency margin for any stray word
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### trie_max_xor_search.f
+incdir+rtl
rtl/tmx_pkg.sv
rtl/tmx_ram.sv
rtl/tmx_ctrl.sv
rtl/tmx_dpath.sv
rtl/trie_max_xor_search.sv
verif/trie_xor_checker.sv
verif/tb.sv
